@@ hdl/pdc_pkg.sv @@
package pdc_pkg;

  // field widths
  localparam int FREQ_W = 32;
  localparam int CLK_W  = 32;
  localparam int PSC_W  = 16;
  localparam int RLD_W  = 16;

  // default counter span of the auto-reload register
  localparam int RELOAD_SPAN_DEF = 65536;

  // largest prescaler, and the prescaler divisor span (max + 1)
  localparam int PSC_MAX  = 65535;
  localparam int PSC_SPAN = PSC_MAX + 1;
  localparam int PDIV_W   = $clog2(PSC_SPAN + 1);

endpackage

@@ hdl/pdc_div.sv @@
module pdc_div #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quot,
  output logic [SIDE_W-1:0] out_side
);

  // per-stage registers, stage s holds the state after s+1 quotient bits
  logic [NUM_W-1:0]  vld_r;
  logic [DEN_W-1:0]  rem_r  [0:NUM_W-1];
  logic [NUM_W-1:0]  num_r  [0:NUM_W-1];
  logic [NUM_W-1:0]  quot_r [0:NUM_W-1];
  logic [DEN_W-1:0]  den_r  [0:NUM_W-1];
  logic [SIDE_W-1:0] side_r [0:NUM_W-1];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic              src_vld;
    logic [DEN_W-1:0]  src_rem;
    logic [NUM_W-1:0]  src_num;
    logic [NUM_W-1:0]  src_quot;
    logic [DEN_W-1:0]  src_den;
    logic [SIDE_W-1:0] src_side;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [DEN_W-1:0]  rem_nxt;

    // stage source: ports for the first stage, previous stage otherwise
    if (s == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = '0;
      assign src_num  = in_num;
      assign src_quot = '0;
      assign src_den  = in_den;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = vld_r[s-1];
      assign src_rem  = rem_r[s-1];
      assign src_num  = num_r[s-1];
      assign src_quot = quot_r[s-1];
      assign src_den  = den_r[s-1];
      assign src_side = side_r[s-1];
    end

    // one restoring step: bring down a numerator bit, trial subtract
    always_comb begin
      trial   = {src_rem, src_num[NUM_W-1]};
      diff    = trial - {1'b0, src_den};
      ge      = (trial >= {1'b0, src_den});
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    // valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= src_vld;
      end
    end

    // payload
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        num_r[s]  <= {src_num[NUM_W-2:0], 1'b0};
        quot_r[s] <= {src_quot[NUM_W-2:0], ge};
        den_r[s]  <= src_den;
        side_r[s] <= src_side;
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign out_quot  = quot_r[NUM_W-1];
  assign out_side  = side_r[NUM_W-1];

endmodule

@@ hdl/pwm_divisor_calculator.sv @@
// PWM prescaler / auto-reload calculator
//
// cfg channel: cfg_data carries the timer input clock in hertz, written on
// cfg_valid (cfg_ready is always high). Write it only while the block is idle.
// in channel: one word per request, in_target_freq_hz, taken when in_valid is
// high and in_stall is low.
// out channel: one word per request, out_prescaler, out_reload and
// out_out_of_range, taken when out_valid is high and out_stall is low.
// Rejected requests (zero, above half the clock, or prescaler wider than
// 16 bits) give zero prescaler and reload with out_out_of_range set.
//
// Stages: input register, a 32-stage pipelined divider for the total divisor,
// four registers for the prescaler (total minus one, reciprocal product,
// quotient, width check), a 32-stage pipelined divider for the reload and the
// output register. Throughput is one word per cycle unless a result is held.
// Reset clears the clock register to zero and empties the pipeline.
// While a result sits on the output and out_stall is high the whole
// pipeline holds and in_stall is raised; nothing is lost or repeated.
module pwm_divisor_calculator
  import pdc_pkg::*;
#(
  parameter int RELOAD_SPAN = RELOAD_SPAN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CLK_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FREQ_W-1:0] in_target_freq_hz,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PSC_W-1:0]  out_prescaler,
  output logic [RLD_W-1:0]  out_reload,
  output logic              out_out_of_range
);

  // reciprocal of the span: floor(x / span) = (x * (2^32 + MAGIC)) >> (32 + l)
  localparam int SPAN_L = $clog2(RELOAD_SPAN);
  localparam int QSH    = CLK_W + SPAN_L;
  localparam logic [63:0] SPAN_POW   = 64'd1 << SPAN_L;
  localparam logic [63:0] SPAN_D     = 64'(RELOAD_SPAN);
  localparam logic [63:0] MAGIC_FULL = (((SPAN_POW - SPAN_D) << CLK_W) / SPAN_D) + 64'd1;
  localparam logic [CLK_W-1:0] MAGIC = MAGIC_FULL[CLK_W-1:0];

  logic              en;
  logic [CLK_W-1:0]  clk_hz_r;

  logic              a_vld_r;
  logic [FREQ_W-1:0] a_freq_r;
  logic [CLK_W-1:0]  a_clk_r;
  logic              a_bad_r;

  logic              d1_vld;
  logic [CLK_W-1:0]  d1_quot;
  logic              d1_bad;

  logic              p1_vld_r;
  logic [CLK_W-1:0]  p1_num_r;
  logic [CLK_W-1:0]  p1_total_r;
  logic              p1_bad_r;

  logic                 m1_vld_r;
  logic [2*CLK_W-1:0]   m1_prod_r;
  logic [CLK_W-1:0]     m1_num_r;
  logic [CLK_W-1:0]     m1_total_r;
  logic                 m1_bad_r;
  logic [2*CLK_W:0]     m1_sum;

  logic              m2_vld_r;
  logic [CLK_W-1:0]  m2_quot_r;
  logic [CLK_W-1:0]  m2_total_r;
  logic              m2_bad_r;

  logic              p2_vld_r;
  logic [CLK_W-1:0]  p2_total_r;
  logic [PDIV_W-1:0] p2_den_r;
  logic [PSC_W-1:0]  p2_psc_r;
  logic              p2_bad_r;

  logic              d3_vld;
  logic [CLK_W-1:0]  d3_quot;
  logic [PSC_W:0]    d3_side;

  logic              out_valid_r;
  logic [PSC_W-1:0]  out_psc_r;
  logic [RLD_W-1:0]  out_rld_r;
  logic              out_bad_r;

  // pipeline advances unless a result is held on the output
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // clock register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= '0;
    end else if (cfg_valid) begin
      clk_hz_r <= cfg_data;
    end
  end

  // input stage: range check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_freq_r <= in_target_freq_hz;
      a_clk_r  <= clk_hz_r;
      a_bad_r  <= (in_target_freq_hz == '0) || (in_target_freq_hz > (clk_hz_r >> 1));
    end
  end

  // total divisor = clock / frequency
  pdc_div #(
    .NUM_W  (CLK_W),
    .DEN_W  (FREQ_W),
    .SIDE_W (1)
  ) u_div_total (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_vld_r),
    .in_num    (a_clk_r),
    .in_den    (a_freq_r),
    .in_side   (a_bad_r),
    .out_valid (d1_vld),
    .out_quot  (d1_quot),
    .out_side  (d1_bad)
  );

  // total minus one, the prescaler is floor((total - 1) / span)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_num_r   <= d1_quot - CLK_W'(1);
      p1_total_r <= d1_quot;
      p1_bad_r   <= d1_bad;
    end
  end

  // 32 x 32 product with the reciprocal of the span
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_prod_r  <= {{CLK_W{1'b0}}, p1_num_r} * {{CLK_W{1'b0}}, MAGIC};
      m1_num_r   <= p1_num_r;
      m1_total_r <= p1_total_r;
      m1_bad_r   <= p1_bad_r;
    end
  end

  // add the implicit top bit of the reciprocal and shift down to the quotient
  assign m1_sum = {1'b0, m1_prod_r} + {1'b0, m1_num_r, {CLK_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_quot_r  <= CLK_W'(m1_sum >> QSH);
      m2_total_r <= m1_total_r;
      m2_bad_r   <= m1_bad_r;
    end
  end

  // prescaler and its width check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_total_r <= m2_total_r;
      p2_den_r   <= PDIV_W'(m2_quot_r + CLK_W'(1));
      p2_psc_r   <= m2_quot_r[PSC_W-1:0];
      p2_bad_r   <= m2_bad_r || (m2_quot_r > CLK_W'(PSC_MAX));
    end
  end

  // reload divisor = total / (prescaler + 1)
  pdc_div #(
    .NUM_W  (CLK_W),
    .DEN_W  (PDIV_W),
    .SIDE_W (PSC_W + 1)
  ) u_div_reload (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p2_vld_r),
    .in_num    (p2_total_r),
    .in_den    (p2_den_r),
    .in_side   ({p2_bad_r, p2_psc_r}),
    .out_valid (d3_vld),
    .out_quot  (d3_quot),
    .out_side  (d3_side)
  );

  // output register, rejected words forced to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bad_r <= d3_side[PSC_W];
      out_psc_r <= d3_side[PSC_W] ? '0 : d3_side[PSC_W-1:0];
      out_rld_r <= d3_side[PSC_W] ? '0 : RLD_W'(d3_quot - CLK_W'(1));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_prescaler    = out_psc_r;
  assign out_reload       = out_rld_r;
  assign out_out_of_range = out_bad_r;

endmodule

@@ hdl/pdc_checker.sv @@
module pdc_checker
  import pdc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PSC_W-1:0] out_prescaler,
  input logic [RLD_W-1:0] out_reload,
  input logic             out_out_of_range
);

  // pipeline is empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // rejected word carries zero prescaler and reload
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_prescaler == '0 && out_reload == '0)
    else $error("rejected word with non-zero fields");

  // accepted word always has a reload of at least one
  a_reload_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |-> out_reload != '0)
    else $error("accepted word with zero reload");

  // a held result blocks the input side
  a_back_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result held");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prescaler)
      && $stable(out_reload) && $stable(out_out_of_range))
    else $error("stalled result changed");

endmodule

bind pwm_divisor_calculator pdc_checker u_pdc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_prescaler    (out_prescaler),
  .out_reload       (out_reload),
  .out_out_of_range (out_out_of_range)
);
